[rtl/rmq_pkg.sv]
// types, constants and helpers shared by the rotation matrix to quaternion block
package rmq_pkg;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic [2:0]         path;
    } quat_t;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_W_THRESHOLD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] W_THRESHOLD_RESET    = 15'd16;
    localparam logic [CFG_W-1:0] AXIS_THRESHOLD_RESET = 15'd2;

    localparam logic [2:0] PATH_DIVIDE = 3'd0;
    localparam logic [2:0] PATH_X      = 3'd1;
    localparam logic [2:0] PATH_Y      = 3'd2;
    localparam logic [2:0] PATH_Z      = 3'd3;
    localparam logic [2:0] PATH_NONE   = 3'd4;

    // root of a 32 bit radicand gives 16 bits; 16 steps of 2 radicand bits
    localparam int unsigned RAD_W  = 32;
    localparam int unsigned ROOT_W = 16;
    // quotient of a 30 bit dividend (|d| * 4096) by a 15 bit divisor
    localparam int unsigned DIVD_W = 30;
    localparam int unsigned QUO_W  = 30;

    // signed result of a magnitude with saturation
    function automatic logic signed [15:0] sat_signed(input logic neg,
                                                      input logic [QUO_W-1:0] q);
        logic signed [15:0] r;
        if (neg)
        begin
            if (q > QUO_W'(32768))
                r = 16'sh8000;
            else
                r = 16'(-$signed({1'b0, q}));
        end
        else
        begin
            if (q > QUO_W'(32767))
                r = 16'sh7fff;
            else
                r = 16'(q);
        end
        return r;
    endfunction

endpackage

[rtl/rmq_sqrt_pipe.sv]
// pipelined integer square root, one result bit per stage
module rmq_sqrt_pipe #(
    parameter int unsigned TAG_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rmq_pkg::RAD_W-1:0]   radicand,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]  root,
    output logic [TAG_W-1:0]            out_tag
);
    localparam int unsigned N = rmq_pkg::ROOT_W;
    localparam int unsigned R = rmq_pkg::RAD_W;

    logic [N:0]       valid_reg;
    logic [R-1:0]     rad_reg  [N+1];
    logic [N+1:0]     rem_reg  [N+1];
    logic [N-1:0]     res_reg  [N+1];
    logic [TAG_W-1:0] tag_reg  [N+1];

    assign valid_reg[0] = in_valid;
    assign rad_reg[0]   = radicand;
    assign rem_reg[0]   = '0;
    assign res_reg[0]   = '0;
    assign tag_reg[0]   = in_tag;

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N+1:0] rem_next;
        logic [N+1:0] trial;
        logic [N+1:0] rem_sh;

        always_comb
        begin
            rem_sh = {rem_reg[s][N-1:0], rad_reg[s][R-1 -: 2]};
            trial  = {res_reg[s], 2'b01};
            if (rem_sh >= trial)
                rem_next = rem_sh - trial;
            else
                rem_next = rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s+1] <= {rad_reg[s][R-3:0], 2'b00};
            rem_reg[s+1] <= rem_next;
            res_reg[s+1] <= {res_reg[s][N-2:0], rem_sh >= trial};
            tag_reg[s+1] <= tag_reg[s];
        end
    end

    assign out_valid = valid_reg[N];
    assign root      = res_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

[rtl/rmq_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage
module rmq_div_pipe #(
    parameter int unsigned TAG_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rmq_pkg::DIVD_W-1:0]  dividend,
    input  logic [14:0]                 divisor,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [rmq_pkg::QUO_W-1:0]   quotient,
    output logic [TAG_W-1:0]            out_tag
);
    localparam int unsigned N = rmq_pkg::DIVD_W;

    logic [N:0]       valid_reg;
    logic [N-1:0]     num_reg [N+1];
    logic [15:0]      rem_reg [N+1];
    logic [14:0]      dvs_reg [N+1];
    logic [TAG_W-1:0] tag_reg [N+1];

    assign valid_reg[0] = in_valid;
    assign num_reg[0]   = dividend;
    assign rem_reg[0]   = '0;
    assign dvs_reg[0]   = divisor;
    assign tag_reg[0]   = in_tag;

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [16:0] rem_sh;
        logic        take;

        always_comb
        begin
            rem_sh = {rem_reg[s], num_reg[s][N-1]};
            take   = rem_sh >= {2'b00, dvs_reg[s]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end

        // quotient bits shift in at the bottom of the dividend word
        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= {num_reg[s][N-2:0], take};
            rem_reg[s+1] <= take ? 16'(rem_sh - {2'b00, dvs_reg[s]}) : rem_sh[15:0];
            dvs_reg[s+1] <= dvs_reg[s];
            tag_reg[s+1] <= tag_reg[s];
        end
    end

    assign out_valid = valid_reg[N];
    assign quotient  = num_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix to quaternion conversion pipeline
// Converts one 3x3 Q2.14 rotation matrix per clock into a Q2.14 quaternion.
// busy is always low, so start may be held every cycle; each beat leaves
// on result with done high after it passes the input register, then 16
// root stages for w and the diagonal roots, 1 decision stage, 30 divider
// stages and the output register (the fallback results wait in a matching
// delay line).
// The throughput is one beat per cycle.
// The receiver cannot stall, so nothing is buffered beyond the pipeline.
// Threshold writes are only legal while no beat is in flight.
module rotation_matrix_to_quaternion (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rmq_pkg::mat_t        operand,
    output logic                 done,
    output rmq_pkg::quat_t       result,
    input  logic                 cfg_we,
    input  logic [rmq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmq_pkg::CFG_W-1:0]     cfg_data
);
    localparam int unsigned DIV_LAT = rmq_pkg::DIVD_W;

    // configuration registers
    logic [14:0] w_thr_reg;
    logic [14:0] axis_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_thr_reg    <= rmq_pkg::W_THRESHOLD_RESET;
            axis_thr_reg <= rmq_pkg::AXIS_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmq_pkg::REG_W_THRESHOLD:    w_thr_reg    <= cfg_data;
                rmq_pkg::REG_AXIS_THRESHOLD: axis_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: trace, diagonal and difference terms
    logic          s0_valid_reg;
    logic [31:0]   s0_wrad_reg;
    logic [31:0]   s0_rad_reg [3];
    logic signed [16:0] s0_diff_reg [3];
    logic signed [15:0] s0_m01_reg, s0_m02_reg, s0_m12_reg;

    logic signed [17:0] trace;
    logic [17:0]        trace_abs;
    logic signed [16:0] diag_a [3];

    always_comb
    begin
        trace = 18'(operand.m00) + 18'(operand.m11) + 18'(operand.m22) + 18'sd16384;
        trace_abs = trace[17] ? 18'(-trace) : trace;
        diag_a[0] = 17'(operand.m00) + 17'sd16384;
        diag_a[1] = 17'(operand.m11) + 17'sd16384;
        diag_a[2] = 17'(operand.m22) + 17'sd16384;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_wrad_reg <= {2'b00, trace_abs, 12'd0};
        for (int i = 0; i < 3; i++)
            s0_rad_reg[i] <= diag_a[i][16] ? 32'd0 : {3'b000, diag_a[i][15:0], 13'd0};
        s0_diff_reg[0] <= 17'(operand.m21) - 17'(operand.m12);
        s0_diff_reg[1] <= 17'(operand.m02) - 17'(operand.m20);
        s0_diff_reg[2] <= 17'(operand.m10) - 17'(operand.m01);
        s0_m01_reg <= operand.m01;
        s0_m02_reg <= operand.m02;
        s0_m12_reg <= operand.m12;
    end

    // roots: tag carries the terms needed after the root stages
    localparam int unsigned TAG_W = 3 * 17 + 3 * 16;
    logic [TAG_W-1:0] sq_tag_in, sq_tag_out;
    logic             sq_valid;
    logic [15:0]      w_root, x_root, y_root, z_root;
    logic             unused_v [3];
    logic [0:0]       unused_t [3];

    assign sq_tag_in = {s0_diff_reg[0], s0_diff_reg[1], s0_diff_reg[2],
                        s0_m01_reg, s0_m02_reg, s0_m12_reg};

    rmq_sqrt_pipe #(.TAG_W(TAG_W)) u_sqrt_w (
        .clk(clk), .rst_n(rst_n), .in_valid(s0_valid_reg), .radicand(s0_wrad_reg),
        .in_tag(sq_tag_in), .out_valid(sq_valid), .root(w_root), .out_tag(sq_tag_out));
    rmq_sqrt_pipe #(.TAG_W(1)) u_sqrt_x (
        .clk(clk), .rst_n(rst_n), .in_valid(s0_valid_reg), .radicand(s0_rad_reg[0]),
        .in_tag(1'b0), .out_valid(unused_v[0]), .root(x_root), .out_tag(unused_t[0]));
    rmq_sqrt_pipe #(.TAG_W(1)) u_sqrt_y (
        .clk(clk), .rst_n(rst_n), .in_valid(s0_valid_reg), .radicand(s0_rad_reg[1]),
        .in_tag(1'b0), .out_valid(unused_v[1]), .root(y_root), .out_tag(unused_t[1]));
    rmq_sqrt_pipe #(.TAG_W(1)) u_sqrt_z (
        .clk(clk), .rst_n(rst_n), .in_valid(s0_valid_reg), .radicand(s0_rad_reg[2]),
        .in_tag(1'b0), .out_valid(unused_v[2]), .root(z_root), .out_tag(unused_t[2]));

    // stage 2: path decision and fallback result
    logic signed [16:0] d_x, d_y, d_z;
    logic signed [15:0] r_m01, r_m02, r_m12;
    logic               is_div;
    rmq_pkg::quat_t     fb;

    assign {d_x, d_y, d_z, r_m01, r_m02, r_m12} = sq_tag_out;

    always_comb
    begin
        is_div  = w_root > {1'b0, w_thr_reg};
        fb.qw   = w_root;
        fb.qx   = x_root;
        fb.qy   = y_root;
        fb.qz   = z_root;
        fb.path = rmq_pkg::PATH_NONE;
        if (is_div)
            fb.path = rmq_pkg::PATH_DIVIDE;
        else if (x_root > {1'b0, axis_thr_reg})
        begin
            fb.path = rmq_pkg::PATH_X;
            if (r_m01[15]) fb.qy = -y_root;
            if (r_m02[15]) fb.qz = -z_root;
        end
        else if (y_root > {1'b0, axis_thr_reg})
        begin
            fb.path = rmq_pkg::PATH_Y;
            if (r_m01[15]) fb.qx = -x_root;
            if (r_m12[15]) fb.qz = -z_root;
        end
        else if (z_root > {1'b0, axis_thr_reg})
        begin
            fb.path = rmq_pkg::PATH_Z;
            if (r_m12[15]) fb.qy = -y_root;
            if (r_m02[15]) fb.qx = -x_root;
        end
    end

    logic           s2_valid_reg;
    rmq_pkg::quat_t s2_res_reg;
    logic [16:0]    s2_mag_reg [3];
    logic [2:0]     s2_neg_reg;
    logic [14:0]    s2_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        s2_res_reg    <= fb;
        s2_w_reg      <= w_root[14:0];
        s2_neg_reg    <= {d_x[16], d_y[16], d_z[16]};
        s2_mag_reg[0] <= d_x[16] ? 17'(-d_x) : d_x;
        s2_mag_reg[1] <= d_y[16] ? 17'(-d_y) : d_y;
        s2_mag_reg[2] <= d_z[16] ? 17'(-d_z) : d_z;
    end

    // dividers; fallback result and signs travel in the x divider tag
    localparam int unsigned DT_W = $bits(rmq_pkg::quat_t) + 3;
    logic [DT_W-1:0] dt_out;
    logic            dv_valid;
    logic [rmq_pkg::QUO_W-1:0] qx_mag, qy_mag, qz_mag;
    logic            unused_dv [2];
    logic [0:0]      unused_dt [2];
    logic [14:0]     div_w;

    // divide path implies w above a threshold, so w is never zero there
    assign div_w = (s2_w_reg == 15'd0) ? 15'd1 : s2_w_reg;

    rmq_div_pipe #(.TAG_W(DT_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(s2_valid_reg),
        .dividend({1'b0, s2_mag_reg[0], 12'd0}), .divisor(div_w),
        .in_tag({s2_res_reg, s2_neg_reg}), .out_valid(dv_valid),
        .quotient(qx_mag), .out_tag(dt_out));
    rmq_div_pipe #(.TAG_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(s2_valid_reg),
        .dividend({1'b0, s2_mag_reg[1], 12'd0}), .divisor(div_w),
        .in_tag(1'b0), .out_valid(unused_dv[0]), .quotient(qy_mag), .out_tag(unused_dt[0]));
    rmq_div_pipe #(.TAG_W(1)) u_div_z (
        .clk(clk), .rst_n(rst_n), .in_valid(s2_valid_reg),
        .dividend({1'b0, s2_mag_reg[2], 12'd0}), .divisor(div_w),
        .in_tag(1'b0), .out_valid(unused_dv[1]), .quotient(qz_mag), .out_tag(unused_dt[1]));

    // output register
    rmq_pkg::quat_t held;
    logic [2:0]     negs;
    rmq_pkg::quat_t fin;

    always_comb
    begin
        {held, negs} = dt_out;
        fin = held;
        if (held.path == rmq_pkg::PATH_DIVIDE)
        begin
            fin.qx = rmq_pkg::sat_signed(negs[2], qx_mag);
            fin.qy = rmq_pkg::sat_signed(negs[1], qy_mag);
            fin.qz = rmq_pkg::sat_signed(negs[0], qz_mag);
        end
    end

    logic done_reg;
    rmq_pkg::quat_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= fin;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a beat taken now leaves exactly at the fixed latency
    localparam int unsigned LAT = 1 + rmq_pkg::ROOT_W + 1 + DIV_LAT + 1;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ##LAT (done == $past(start, LAT)))
        else $error("result strobe out of step with start");

    a_path_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.path <= rmq_pkg::PATH_NONE))
        else $error("path code out of range");

    // largest trace magnitude is 3 * 32767 + 16384; the root of it times 4096 is 21673
    a_w_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.qw >= 0 && result.qw <= 16'sd21673))
        else $error("w outside its range");
endmodule
